FILE: rtl/core/dbd_pkg.sv
// Package for the days_between_dates block: request and response payload types,
// calendar constants and the month tables. No dependencies.
package dbd_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned LEN_W   = 22;
  // Day numbers and partial sums; wide enough for 365 * 16383.
  localparam int unsigned DN_W    = 23;
  localparam int unsigned Q100_W  = 8;
  localparam int unsigned R100_W  = 7;
  localparam int unsigned LEAPS_W = 13;
  localparam int unsigned DOY_W   = 10;
  localparam int unsigned DBM_W   = 9;

  localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  // floor(y / 100) = (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y
  localparam int unsigned RECIP_100_W = 13;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned PROD_W      = YEAR_W + RECIP_100_W;
  localparam logic [RECIP_100_W-1:0] RECIP_100 = RECIP_100_W'(5243);
  localparam logic [YEAR_W-1:0]      CENTURY   = YEAR_W'(100);
  localparam logic [DN_W-1:0]        DAYS_YEAR = DN_W'(365);

  typedef struct packed {
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [YEAR_W-1:0]  end_year;
    logic [MONTH_W-1:0] end_month;
    logic [DAY_W-1:0]   end_day;
    logic               include_end;
  } dbd_req_t;

  typedef struct packed {
    logic [LEN_W-1:0] length_days;
    logic             bad_date;
  } dbd_rsp_t;

  // Days in a month; zero for codes that are no month.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    n = DAY_W'(30);
      4'd2:                                       n = leap ? DAY_W'(29) : DAY_W'(28);
      default:                                    n = '0;
    endcase
    return n;
  endfunction

  // Days in the year before the first of the month (common year).
  function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [DBM_W-1:0] n;
    unique case (m)
      4'd1:    n = DBM_W'(0);
      4'd2:    n = DBM_W'(31);
      4'd3:    n = DBM_W'(59);
      4'd4:    n = DBM_W'(90);
      4'd5:    n = DBM_W'(120);
      4'd6:    n = DBM_W'(151);
      4'd7:    n = DBM_W'(181);
      4'd8:    n = DBM_W'(212);
      4'd9:    n = DBM_W'(243);
      4'd10:   n = DBM_W'(273);
      4'd11:   n = DBM_W'(304);
      4'd12:   n = DBM_W'(334);
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/core/days_between_dates.sv
// Days between two Gregorian dates: five-stage pipeline from request to response.
// Depends on dbd_pkg.
//
// Usage:
//   The request channel (req_valid/req_ready/req_data) carries a start date, an
//   end date and an include_end flag. The response channel (rsp_valid/rsp_ready/
//   rsp_data) returns one item per request, in order: length_days is the end day
//   number minus the start day number (zero when start is not before end), plus
//   one when include_end is set. bad_date flags a date with year above 9999,
//   month outside 1..12 or a day of zero or beyond its month; length_days is then zero.
//   Throughput: one request per cycle while rsp_ready is high. The deepest paths are
//   the constant multiplies (14x13 for year / 100 in stage 1, by 100 and by 365 in
//   stage 2); the other stages are short chains of adds, so five register stages carry it.
//   Stall: when rsp_ready is low the response is held; each stage keeps its item
//   until the next stage frees up, bubbles are squeezed out, and req_ready drops
//   only when all five stages are full.
//   Reset: rst (synchronous) clears every stage valid bit; the pipeline is empty
//   and req_ready is high in the first cycle after reset.
module days_between_dates (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  dbd_pkg::dbd_req_t  req_data,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output dbd_pkg::dbd_rsp_t  rsp_data
);
  import dbd_pkg::*;

  localparam int unsigned NDATE = 2;  // index 0: start date, 1: end date

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [Q100_W-1:0]  q100;
  } s1_date_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [Q100_W-1:0]  q100;
    logic [R100_W-1:0]  r100;
    logic [DN_W-1:0]    y365;
  } s2_date_t;

  typedef struct packed {
    logic [DN_W-1:0]  part_year;
    logic [DOY_W-1:0] part_doy;
    logic             ok;
  } s3_date_t;

  typedef struct packed {
    logic [DN_W-1:0] dn_start;
    logic [DN_W-1:0] dn_end;
    logic            bad;
    logic            inc;
  } s4_t;

  // Stage registers
  logic                 v1, v2, v3, v4, v5;
  s1_date_t [NDATE-1:0] s1;
  s2_date_t [NDATE-1:0] s2;
  s3_date_t [NDATE-1:0] s3;
  logic                 inc1, inc2, inc3;
  s4_t                  s4;
  dbd_rsp_t             rsp_reg;

  // Stage inputs
  s1_date_t [NDATE-1:0] s1_next;
  s2_date_t [NDATE-1:0] s2_next;
  s3_date_t [NDATE-1:0] s3_next;
  s4_t                  s4_next;
  dbd_rsp_t             rsp_next;

  logic en1, en2, en3, en4, en5;

  // Each stage advances when it is empty or its successor advances
  assign en5 = !v5 || rsp_ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign req_ready = en1;

  // Stage 1: split dates, divide year by 100 with a reciprocal multiply
  always_comb begin
    logic [PROD_W-1:0] prod [NDATE];
    s1_next[0].year  = req_data.start_year;
    s1_next[0].month = req_data.start_month;
    s1_next[0].day   = req_data.start_day;
    s1_next[1].year  = req_data.end_year;
    s1_next[1].month = req_data.end_month;
    s1_next[1].day   = req_data.end_day;
    for (int i = 0; i < NDATE; i++) begin
      prod[i] = PROD_W'(s1_next[i].year) * PROD_W'(RECIP_100);
      s1_next[i].q100 = prod[i][RECIP_SHIFT +: Q100_W];
    end
  end

  // Stage 2: remainder of year / 100 and 365 * year
  always_comb begin
    logic [YEAR_W-1:0] rem [NDATE];
    for (int i = 0; i < NDATE; i++) begin
      rem[i] = s1[i].year - YEAR_W'(s1[i].q100) * CENTURY;
      s2_next[i].year  = s1[i].year;
      s2_next[i].month = s1[i].month;
      s2_next[i].day   = s1[i].day;
      s2_next[i].q100  = s1[i].q100;
      s2_next[i].r100  = rem[i][R100_W-1:0];
      s2_next[i].y365  = DN_W'(s1[i].year) * DAYS_YEAR;
    end
  end

  // Stage 3: leap rule, leap days before the year, validity, day of year
  always_comb begin
    logic               rnz   [NDATE];
    logic               leap  [NDATE];
    logic [LEAPS_W-1:0] by4   [NDATE];
    logic [LEAPS_W-1:0] by100 [NDATE];
    logic [LEAPS_W-1:0] by400 [NDATE];
    logic [LEAPS_W-1:0] leaps [NDATE];
    logic [YEAR_W:0]    y3    [NDATE];
    for (int i = 0; i < NDATE; i++) begin
      rnz[i]   = (s2[i].r100 != '0);
      leap[i]  = (s2[i].year[1:0] == 2'b00) && (rnz[i] || (s2[i].q100[1:0] == 2'b00));
      y3[i]    = (YEAR_W + 1)'(s2[i].year) + (YEAR_W + 1)'(3);
      by4[i]   = LEAPS_W'(y3[i] >> 2);
      by100[i] = LEAPS_W'(s2[i].q100) + LEAPS_W'(rnz[i]);
      by400[i] = LEAPS_W'(s2[i].q100 >> 2)
               + LEAPS_W'(rnz[i] || (s2[i].q100[1:0] != 2'b00));
      leaps[i] = by4[i] - by100[i] + by400[i];
      s3_next[i].part_year = s2[i].y365 + DN_W'(leaps[i]);
      s3_next[i].part_doy  = DOY_W'(days_before_month(s2[i].month))
                           + DOY_W'(s2[i].day)
                           + DOY_W'((s2[i].month > MONTH_FEB) && leap[i]);
      s3_next[i].ok = (s2[i].year <= YEAR_MAX)
                   && (s2[i].month >= MONTH_JAN) && (s2[i].month <= MONTH_DEC)
                   && (s2[i].day != '0)
                   && (s2[i].day <= month_days(s2[i].month, leap[i]));
    end
  end

  // Stage 4: full day numbers and the combined error flag
  always_comb begin
    s4_next.dn_start = s3[0].part_year + DN_W'(s3[0].part_doy);
    s4_next.dn_end   = s3[1].part_year + DN_W'(s3[1].part_doy);
    s4_next.bad      = !s3[0].ok || !s3[1].ok;
    s4_next.inc      = inc3;
  end

  // Stage 5: difference, clamp at zero, add the end day if include_end, zero on a bad date
  always_comb begin
    logic [DN_W-1:0] diff;
    diff = (s4.dn_start < s4.dn_end) ? (s4.dn_end - s4.dn_start) : '0;
    diff = diff + DN_W'(s4.inc);
    rsp_next.bad_date    = s4.bad;
    rsp_next.length_days = s4.bad ? '0 : diff[LEN_W-1:0];
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= req_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // Payload registers: load when the stage advances, hold otherwise
  always_ff @(posedge clk) begin
    if (en1) begin
      s1   <= s1_next;
      inc1 <= req_data.include_end;
    end
    if (en2) begin
      s2   <= s2_next;
      inc2 <= inc1;
    end
    if (en3) begin
      s3   <= s3_next;
      inc3 <= inc2;
    end
    if (en4) s4 <= s4_next;
    if (en5) rsp_reg <= rsp_next;
  end

  assign rsp_valid = v5;
  assign rsp_data  = rsp_reg;

endmodule

FILE: rtl/core/dbd_checker.sv
// Port-level checker for days_between_dates, bound to the top level below.
// Depends on dbd_pkg.
module dbd_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input dbd_pkg::dbd_req_t req_data,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input dbd_pkg::dbd_rsp_t rsp_data
);
  import dbd_pkg::*;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(3652426);

  // Hold a waiting request
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req_data))
    else $error("waiting request changed or dropped");

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response changed or dropped");

  // A bad date never carries a length
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.bad_date |-> rsp_data.length_days == '0)
    else $error("bad date with nonzero length");

  // Length stays within the span of years 0 to 9999
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.length_days <= LEN_MAX)
    else $error("length out of range");

  // Pipeline comes out of reset empty and ready
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("pipeline not empty after reset");

endmodule

bind days_between_dates dbd_checker u_dbd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req_data  (req_data),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);
